// File: design/btd_pkg.sv
// btd_pkg: shared types, constants and the unit decoder of the byte-level token decoder.
// Used by btd_front, btd_queue, btd_back and byte_level_token_text_decoder.
package btd_pkg;

  localparam int WIN_DEPTH = 6;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;

  // escape characters
  localparam logic [7:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_X    = 8'h78;  // 'x'
  localparam logic [7:0] CH_GT   = 8'h3E;  // '>'

  // UTF-8 lead / continuation masks
  localparam logic [7:0] MASK_C0 = 8'hC0;
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] MASK_F8 = 8'hF8;
  localparam logic [7:0] CONT_TAG = 8'h80;
  localparam logic [7:0] LEAD2    = 8'hC0;
  localparam logic [7:0] LEAD3    = 8'hE0;
  localparam logic [7:0] LEAD4    = 8'hF0;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // one decoded unit: bytes consumed, bytes produced, produced bytes
  typedef struct packed {
    logic [2:0]      used;
    logic [2:0]      nb;
    logic [3:0][7:0] data;
  } unit_t;

  // one queue entry: cnt bytes (1..4) of data, or a bare end marker
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            last;
    logic            bare;
  } entry_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = 8'd0;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      r = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c & MASK_C0) == CONT_TAG;
  endfunction

  function automatic logic kept_byte(input logic [7:0] b);
    return (b >= 8'd33 && b <= 8'd126) || (b >= 8'd161 && b <= 8'd172) || (b >= 8'd174);
  endfunction

  // inverse byte-to-unicode map: {hit, byte}
  function automatic logic [8:0] inv_map(input logic [20:0] cp);
    logic [9:0] k;
    logic [8:0] r;
    k = cp[9:0] - 10'd256;
    r = 9'd0;
    if (cp[20:10] == 11'd0) begin
      if (cp[9:8] == 2'd0) begin
        r = {kept_byte(cp[7:0]), cp[7:0]};
      end else if (k < 10'd33) begin
        r = {1'b1, k[7:0]};
      end else if (k < 10'd67) begin
        r = {1'b1, k[7:0] + 8'd94};
      end else if (k == 10'd67) begin
        r = {1'b1, 8'd173};
      end
    end
    return r;
  endfunction

  // decode the unit at the head of w, given avail valid bytes
  function automatic unit_t decode_unit(input win_t w, input logic [2:0] avail);
    unit_t      u;
    logic [4:0] h3;
    logic [4:0] h4;
    logic [20:0] cp;
    logic [8:0] m;
    h3 = hex_val(w[3]);
    h4 = hex_val(w[4]);
    cp = {13'd0, w[0]};
    m  = 9'd0;
    u.used = 3'd1;
    u.nb   = 3'd1;
    u.data = {w[3], w[2], w[1], w[0]};
    if (avail == 3'd6 && w[0] == CH_LT && w[1] == CH_ZERO && w[2] == CH_X &&
        w[5] == CH_GT && h3[4] && h4[4]) begin
      u.used    = 3'd6;
      u.data[0] = {h3[3:0], h4[3:0]};
    end else begin
      priority if (!w[0][7]) begin
        u.used = 3'd1;
      end else if ((w[0] & MASK_E0) == LEAD2 && avail >= 3'd2 && is_cont(w[1])) begin
        cp     = {10'd0, w[0][4:0], w[1][5:0]};
        u.used = 3'd2;
      end else if ((w[0] & MASK_F0) == LEAD3 && avail >= 3'd3 && is_cont(w[1]) &&
                   is_cont(w[2])) begin
        cp     = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
        u.used = 3'd3;
      end else if ((w[0] & MASK_F8) == LEAD4 && avail >= 3'd4 && is_cont(w[1]) &&
                   is_cont(w[2]) && is_cont(w[3])) begin
        cp     = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        u.used = 3'd4;
      end else begin
        u.used = 3'd1;
      end
      m = inv_map(cp);
      if (m[8]) begin
        u.data[0] = m[7:0];
      end else begin
        u.nb = u.used;
      end
    end
    return u;
  endfunction

endpackage

// File: design/btd_front.sv
// btd_front: lookahead window, unit decoding, output budget and end-of-token drain.
// Depends on btd_pkg; feeds btd_queue.
module btd_front #(
  parameter int OUT_CAPACITY = 4096
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_end_of_token,
  input  logic            q_full,
  output logic            push,
  output btd_pkg::entry_t push_entry
);

  localparam int CW = $clog2(OUT_CAPACITY);
  localparam int RW = (CW > 3) ? CW : 3;
  localparam logic [RW-1:0] CAP_M1 = RW'(OUT_CAPACITY - 1);

  btd_pkg::win_t  win_r, win_nxt, win_app, src;
  logic [2:0]     fill_r, fill_nxt, avail;
  logic           drain_r, drain_nxt;
  logic           any_r, any_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  btd_pkg::unit_t u;
  logic           accept, mid_dec, dec_go, fin;
  logic [RW-1:0]  room;
  logic [2:0]     k;
  logic           hit;

  assign in_stall = drain_r || q_full;
  assign accept   = in_valid && !in_stall;
  assign mid_dec  = accept && !in_end_of_token && (fill_r == 3'd5);
  assign dec_go   = mid_dec || (drain_r && !q_full);

  always_comb begin
    win_app = win_r;
    win_app[fill_r] = in_byte;
  end

  assign src   = drain_r ? win_r : win_app;
  assign avail = drain_r ? fill_r : 3'd6;
  assign u     = btd_pkg::decode_unit(src, avail);
  assign fin   = drain_r && (u.used == fill_r);

  // trim to the room left in the budget
  assign room = CAP_M1 - RW'(count_r);
  assign k    = (room < RW'(u.nb)) ? room[2:0] : u.nb;
  assign hit  = (RW'(k) == room);

  always_comb begin
    push_entry.data = u.data;
    push_entry.cnt  = k;
    push_entry.last = drain_r && (fin || hit);
    push_entry.bare = 1'b0;
    push = dec_go && (k != 3'd0);
    if (drain_r && k == 3'd0 && fin && !any_r) begin
      // nothing came out of this token end: bare end marker
      push            = dec_go;
      push_entry.data = '0;
      push_entry.cnt  = 3'd1;
      push_entry.last = 1'b1;
      push_entry.bare = 1'b1;
    end
  end

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    drain_nxt = drain_r;
    any_nxt   = any_r;
    count_nxt = count_r;
    if (dec_go) begin
      win_nxt   = src >> {u.used, 3'b000};
      fill_nxt  = avail - u.used;
      count_nxt = count_r + CW'(k);
      if (drain_r) begin
        any_nxt = any_r || (k != 3'd0);
        if (fin) begin
          drain_nxt = 1'b0;
          any_nxt   = 1'b0;
          count_nxt = '0;
          fill_nxt  = 3'd0;
        end
      end
    end else if (accept) begin
      win_nxt  = win_app;
      fill_nxt = fill_r + 3'd1;
      if (in_end_of_token) begin
        drain_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (!rst_n) begin
      fill_r  <= 3'd0;
      drain_r <= 1'b0;
      any_r   <= 1'b0;
      count_r <= '0;
    end else begin
      fill_r  <= fill_nxt;
      drain_r <= drain_nxt;
      any_r   <= any_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/btd_queue.sv
// btd_queue: short FIFO of decoded units between front and back.
// Depends on btd_pkg.
module btd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  btd_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output btd_pkg::entry_t head
);

  btd_pkg::entry_t             mem_r [btd_pkg::QDEPTH];
  logic [btd_pkg::QAW-1:0]     wp_r, rp_r;
  logic [btd_pkg::QAW:0]       cnt_r;

  assign full      = (cnt_r == (btd_pkg::QAW+1)'(btd_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: design/btd_back.sv
// btd_back: serializes queued units into single result bytes through an output register.
// Depends on btd_pkg; reads btd_queue.
module btd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  btd_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_last
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       bv_r, last_r;
  logic [1:0] sub_r;
  logic       load, end_sub;

  assign load    = q_valid && (!valid_r || !out_stall);
  assign end_sub = ({1'b0, sub_r} == head.cnt - 3'd1);
  assign pop     = load && end_sub;

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bv_r;
  assign out_last       = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bare ? 8'd0 : head.data[sub_r];
      bv_r   <= !head.bare;
      last_r <= head.last && end_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sub_r   <= end_sub ? 2'd0 : sub_r + 2'd1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: design/byte_level_token_text_decoder.sv
// Byte-level token text decoder. Bytes of one token's vocabulary string enter one per
// transfer, the final one flagged by in_end_of_token; raw bytes leave one per transfer,
// with out_last on the final result of the token (a bare marker with out_byte_valid low
// when the drain at the token's end produced nothing). Mid-token the input side takes one
// byte per cycle while the queue is not full; the byte that ends a token is followed by a
// drain of the units still held in the six-byte window, during which in_stall is high.
// The output side moves one result per cycle while out_stall is low, so a unit that
// passes its 2 to 4 bytes through keeps the back end busy longer; a four-entry unit queue
// absorbs the difference, and the input stalls while it is full. Results per token are
// capped at OUT_CAPACITY - 1 bytes. Depends on btd_pkg, btd_front, btd_queue, btd_back.
module byte_level_token_text_decoder #(
  parameter int OUT_CAPACITY = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_token,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

  btd_pkg::entry_t push_entry, head;
  logic            push, q_full, q_valid, pop;

  // front: window, escape / UTF-8 decode, inverse byte map, budget, drain at token end
  btd_front #(
    .OUT_CAPACITY(OUT_CAPACITY)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_end_of_token (in_end_of_token),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  // decoupling queue of whole units
  btd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  // back: one byte per transfer out of the output register
  btd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

endmodule

// File: tb/tb_byte_level_token_text_decoder.sv
// Self-checking testbench for byte_level_token_text_decoder: streams token strings and
// checks every decoded byte against a built-in predictor. Depends on btd_pkg and the RTL.
module tb_byte_level_token_text_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OUT_CAPACITY   = 4096;
  localparam int END_TAIL       = 40;         // quiet cycles after the last expected result
  localparam int HOLD_CYCLES    = 150;        // long receiver hold-off
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // one input transfer as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       drain_first;  // sender waits until all results are back
  } tok_byte_t;

  // one result transfer
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       is_last;
  } dec_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_token = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_last;

  byte_level_token_text_decoder #(
    .OUT_CAPACITY(OUT_CAPACITY)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_token(in_end_of_token),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tok_byte_t   pending_q[$];    // bytes waiting to be sent
  dec_result_t expected_q[$];   // decoded bytes still owed by the block
  dec_result_t arrived_q[$];    // results taken this cycle, checked at the falling edge

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count = 0;
  int hold_mark = 32'h7fff_ffff;  // sent_count at which the receiver hold-off begins
  int mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Decoder predictor: its own six-byte lookahead window and per-token byte count.
  // ---------------------------------------------------------------------------
  logic [7:0] win_bytes [btd_pkg::WIN_DEPTH] = '{default: 8'h00};
  int         win_fill = 0;
  int         tok_emitted = 0;
  logic [7:0] step_out[$];      // bytes produced by the transfer being predicted

  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic bit is_trailing(logic [7:0] c);
    return (c & btd_pkg::MASK_C0) == btd_pkg::CONT_TAG;
  endfunction

  // Inverse of the byte-to-unicode table; -1 where the code point has no entry.
  function automatic int byte_for_codepoint(int unsigned cp);
    int unsigned k;
    if (cp >= 1024) return -1;
    if (cp < 256) begin
      if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) || cp >= 174) return int'(cp);
      return -1;
    end
    k = cp - 256;
    if (k < 33) return int'(k);
    if (k < 67) return int'(127 + k - 33);
    if (k == 67) return 173;
    return -1;
  endfunction

  // Output stops once the token is at capacity; never more than six per transfer.
  function automatic void emit_byte(logic [7:0] b);
    if (tok_emitted >= OUT_CAPACITY - 1 || step_out.size() >= btd_pkg::WIN_DEPTH) return;
    step_out.push_back(b);
    tok_emitted++;
  endfunction

  // Decode the unit at the head of the window, emit its bytes, drop it from the window.
  function automatic void decode_head();
    logic [7:0]  c0, c1, c2, c3;
    int unsigned cp;
    int          used, mapped, d_hi, d_lo;
    c0 = win_bytes[0];
    c1 = win_bytes[1];
    c2 = win_bytes[2];
    c3 = win_bytes[3];
    d_hi = hex_digit(c3);
    d_lo = hex_digit(win_bytes[4]);
    used = 1;
    cp = 32'(c0);
    if (win_fill == btd_pkg::WIN_DEPTH && c0 == btd_pkg::CH_LT &&
        c1 == btd_pkg::CH_ZERO && c2 == btd_pkg::CH_X &&
        win_bytes[5] == btd_pkg::CH_GT && d_hi >= 0 && d_lo >= 0) begin
      emit_byte({d_hi[3:0], d_lo[3:0]});
      used = 6;
    end else begin
      // invalid or short sequences keep the lead byte as the code point
      if ((c0 & btd_pkg::MASK_E0) == btd_pkg::LEAD2 && win_fill >= 2 &&
          is_trailing(c1)) begin
        cp = 32'({c0[4:0], c1[5:0]});
        used = 2;
      end else if ((c0 & btd_pkg::MASK_F0) == btd_pkg::LEAD3 && win_fill >= 3 &&
                   is_trailing(c1) && is_trailing(c2)) begin
        cp = 32'({c0[3:0], c1[5:0], c2[5:0]});
        used = 3;
      end else if ((c0 & btd_pkg::MASK_F8) == btd_pkg::LEAD4 && win_fill >= 4 &&
                   is_trailing(c1) && is_trailing(c2) && is_trailing(c3)) begin
        cp = 32'({c0[2:0], c1[5:0], c2[5:0], c3[5:0]});
        used = 4;
      end
      mapped = byte_for_codepoint(cp);
      if (mapped >= 0) begin
        emit_byte(mapped[7:0]);
      end else begin
        for (int i = 0; i < used; i++) emit_byte(win_bytes[i]);
      end
    end
    for (int i = 0; i < btd_pkg::WIN_DEPTH; i++)
      win_bytes[i] = (i + used < btd_pkg::WIN_DEPTH) ? win_bytes[i + used] : 8'h00;
    win_fill -= used;
  endfunction

  // Advance the predictor by one accepted byte and queue what it must produce.
  function automatic void predict_item(logic [7:0] b, logic eot);
    if (win_fill < btd_pkg::WIN_DEPTH) begin
      win_bytes[win_fill] = b;
      win_fill++;
    end
    step_out.delete();
    if (eot) begin
      while (win_fill > 0) decode_head();
      if (step_out.size() == 0) begin
        expected_q.push_back('{8'h00, 1'b0, 1'b1});  // bare end marker
      end else begin
        foreach (step_out[i])
          expected_q.push_back('{step_out[i], 1'b1, 1'(i == step_out.size() - 1)});
      end
      foreach (win_bytes[i]) win_bytes[i] = 8'h00;
      win_fill = 0;
      tok_emitted = 0;
    end else begin
      if (win_fill >= btd_pkg::WIN_DEPTH) decode_head();
      foreach (step_out[i]) expected_q.push_back('{step_out[i], 1'b1, 1'b0});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transfer per accepted byte; payload held while stalled.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    tok_byte_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_byte, in_end_of_token);
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        // a drain-first byte waits until the block has returned everything owed
        if (pending_q.size() != 0 && !(pending_q[0].drain_first && expected_q.size() != 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          in_valid        <= 1'b1;
          in_byte         <= nxt.data;
          in_end_of_token <= nxt.eot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: captures result transfers and drives out_stall, including one long
  // hold-off (counted here) that backs the block up into its input.
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin : result_monitor
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) arrived_q.push_back('{out_byte, out_byte_valid, out_last});
      if (!hold_done && sent_count >= hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  function automatic void report_mismatch(string what, dec_result_t want, dec_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t result error (%s): want %02h/%0b/%0b, got %02h/%0b/%0b",
               $realtime, what, want.data, want.has_data, want.is_last,
               got.data, got.has_data, got.is_last);
  endfunction

  // Compare at the falling edge so capture and prediction order within a step is moot.
  always @(negedge clk) begin : result_checker
    dec_result_t got, want;
    while (arrived_q.size() != 0) begin
      got = arrived_q.pop_front();
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.data != want.data || got.has_data != want.has_data || got.is_last != want.is_last)
          report_mismatch("field", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_token(input logic [7:0] t[$], input bit drain);
    for (int i = 0; i < t.size(); i++)
      pending_q.push_back('{t[i], 1'(i == t.size() - 1), 1'((i == 0) && drain)});
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'h30 + 8'(v);
    if (v < 16) return 8'h41 + 8'(v - 10);
    return 8'h61 + 8'(v - 16);
  endfunction

  function automatic logic [7:0] trail_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // Mostly well-formed units (ASCII, escapes, UTF-8 of every length) with noise mixed in.
  function automatic void queue_random_tokens(int n_items, bit drain_first_one);
    int         n, units, kind;
    bit         drain;
    logic [7:0] t[$];
    logic [7:0] esc [6];
    n = 0;
    drain = drain_first_one;
    while (n < n_items) begin
      t.delete();
      units = $urandom_range(1, 6);
      for (int u = 0; u < units; u++) begin
        kind = $urandom_range(0, 11);
        case (kind)
          0, 1, 2: t.push_back(8'($urandom_range(33, 126)));
          3: t.push_back(($urandom_range(0, 1) != 0) ? 8'd127 : 8'($urandom_range(0, 32)));
          4, 5: begin
            esc[0] = btd_pkg::CH_LT;
            esc[1] = btd_pkg::CH_ZERO;
            esc[2] = btd_pkg::CH_X;
            esc[3] = hex_char();
            esc[4] = hex_char();
            esc[5] = btd_pkg::CH_GT;
            if (kind == 5) esc[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
            foreach (esc[k]) t.push_back(esc[k]);
          end
          6: begin  // code points 256..1023, including the table entries 256..323
            t.push_back(8'($urandom_range(8'hC4, 8'hCF)));
            t.push_back(trail_byte());
          end
          7: begin
            t.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            t.push_back(trail_byte());
          end
          8: begin
            t.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) t.push_back(trail_byte());
          end
          9: begin
            t.push_back(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (3) t.push_back(trail_byte());
          end
          10: t.push_back(8'($urandom_range(0, 255)));
          default: begin  // lead byte with up to two trailing bytes, often a truncated sequence
            t.push_back(8'($urandom_range(8'hC0, 8'hF7)));
            repeat ($urandom_range(0, 2)) t.push_back(trail_byte());
          end
        endcase
      end
      queue_token(t, drain || ($urandom_range(0, 29) == 0));
      drain = 1'b0;
      n += t.size();
    end
  endfunction

  task automatic wait_stimulus_taken();
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] tok[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // phase 1: sender rarely idle, receiver mostly stalled
    send_idle_pct = 9;
    recv_idle_pct = 76;

    // escape, decimal digits
    tok = '{btd_pkg::CH_LT, btd_pkg::CH_ZERO, btd_pkg::CH_X, 8'h34, 8'h31, btd_pkg::CH_GT};
    queue_token(tok, 1'b0);
    // escape, mixed case
    tok = '{btd_pkg::CH_LT, btd_pkg::CH_ZERO, btd_pkg::CH_X, 8'h66, 8'h46, btd_pkg::CH_GT};
    queue_token(tok, 1'b0);
    tok = '{8'h00};                    // zero byte is plain data
    queue_token(tok, 1'b0);
    tok = '{8'hFF};                    // stray lead byte in the table
    queue_token(tok, 1'b0);
    tok = '{8'hC4, 8'hA0};             // table entry above 255
    queue_token(tok, 1'b0);
    tok = '{8'hE4, 8'hB8, 8'h80};      // three-byte pass through
    queue_token(tok, 1'b0);
    tok = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    queue_token(tok, 1'b0);
    tok = '{8'hE4, 8'hB8};             // sequence cut short by the token end
    queue_token(tok, 1'b0);
    tok = '{8'hC0, 8'h80};             // overlong form
    queue_token(tok, 1'b0);
    tok = '{8'hAD};                    // the one gap in the upper table range
    queue_token(tok, 1'b0);

    queue_random_tokens(150, 1'b1);
    wait_stimulus_taken();

    // phase 2: roles swapped
    send_idle_pct = 76;
    recv_idle_pct = 9;
    queue_random_tokens(150, 1'b1);
    wait_stimulus_taken();

    // phase 3: no idling, one long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_mark = sent_count + 40;
    queue_random_tokens(60, 1'b0);
    queue_random_tokens(70, 1'b0);
    wait_stimulus_taken();

    while (expected_q.size() != 0) @(posedge clk);
    repeat (END_TAIL) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 20);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
